// ----- rtl/core/bspq_pkg.sv -----
// Shared types and constants of the banked sorted priority queue.
`default_nettype none

package bspq_pkg;

  localparam int ID_W    = 32;
  localparam int PRIO_W  = 3;
  localparam int TIME_W  = 32;
  localparam int KEY_W   = PRIO_W + TIME_W;
  localparam int DEPT_W  = 3;
  localparam int COUNT_W = 5;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 80;

  typedef enum logic [2:0] {
    ST_INSERTED    = 3'd0,
    ST_NOT_WAITING = 3'd1,
    ST_DUPLICATE   = 3'd2,
    ST_FULL        = 3'd3,
    ST_POPPED      = 3'd4,
    ST_EMPTY       = 3'd5
  } status_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_POP    = 1'b1
  } action_t;

  // One stored queue entry; {prio, rtime} is the sort key.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] rtime;
    logic [ID_W-1:0]   id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    action_t action;
    entry_t  entry;
    logic    waiting;
  } req_t;

  typedef struct packed {
    status_t status;
    entry_t  entry;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/bspq_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module bspq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/core/bspq_seq.sv -----
// Sequencer that scans, shifts and pops one bank of the entry memory.
`default_nettype none

module bspq_seq #(
  parameter int QUEUE_DEPTH = 16,
  parameter int BANK_W      = 3,
  parameter int SLOT_W      = 4,
  parameter int CNT_W       = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire bspq_pkg::req_t    req,
  input  wire logic [BANK_W-1:0] bank,
  input  wire logic              bank_ok,
  input  wire logic [CNT_W-1:0]  bank_cnt,
  input  wire logic              out_free,
  output logic                   ready,
  output logic                   done,
  output bspq_pkg::rsp_t         rsp,
  output logic [CNT_W-1:0]       rsp_cnt
);

  localparam int ADDR_W = BANK_W + SLOT_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_POP   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  bspq_pkg::req_t        req_r, req_nxt;
  logic [BANK_W-1:0]     bank_r, bank_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      pos_r, pos_nxt;
  logic                  pend_r, pend_nxt;
  logic                  dup_r, dup_nxt;
  logic                  found_r, found_nxt;
  bspq_pkg::rsp_t        rsp_r, rsp_nxt;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  bspq_pkg::entry_t      ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  bspq_pkg::entry_t      ram_rdata;

  logic [CNT_W-1:0]      idx_dec, idx_inc, idx_dec2;
  logic                  id_eq, key_gt;
  logic                  dup_any;
  logic [CNT_W-1:0]      pos_fin;

  // Shared compare unit: id match and key order against the pending request.
  assign id_eq  = (ram_rdata.id == req_r.entry.id);
  assign key_gt = ({ram_rdata.prio, ram_rdata.rtime} >
                   {req_r.entry.prio, req_r.entry.rtime});

  assign idx_dec  = idx_r - CNT_W'(1);
  assign idx_inc  = idx_r + CNT_W'(1);
  assign idx_dec2 = idx_r - CNT_W'(2);

  assign dup_any = dup_r || ((idx_r != '0) && id_eq);

  always_comb begin
    pos_fin = cnt_r;
    if (found_r) begin
      pos_fin = pos_r;
    end else if ((idx_r != '0) && key_gt) begin
      pos_fin = idx_dec;
    end
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    bank_nxt  = bank_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    pend_nxt  = pend_r;
    dup_nxt   = dup_r;
    found_nxt = found_r;
    rsp_nxt   = rsp_r;
    ram_we    = 1'b0;
    ram_waddr = {bank_r, idx_r[SLOT_W-1:0]};
    ram_wdata = ram_rdata;
    ram_raddr = {bank_r, idx_r[SLOT_W-1:0]};
    done      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt       = req;
          bank_nxt      = bank;
          cnt_nxt       = bank_ok ? bank_cnt : '0;
          idx_nxt       = '0;
          pend_nxt      = 1'b0;
          dup_nxt       = 1'b0;
          found_nxt     = 1'b0;
          pos_nxt       = '0;
          rsp_nxt.entry = '0;
          priority if (!bank_ok) begin
            if (req.action == bspq_pkg::ACT_POP) begin
              rsp_nxt.status = bspq_pkg::ST_EMPTY;
            end else if (req.waiting) begin
              rsp_nxt.status = bspq_pkg::ST_FULL;
            end else begin
              rsp_nxt.status = bspq_pkg::ST_NOT_WAITING;
            end
            state_nxt = S_DONE;
          end else if (req.action == bspq_pkg::ACT_POP) begin
            if (bank_cnt == '0) begin
              rsp_nxt.status = bspq_pkg::ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              rsp_nxt.status = bspq_pkg::ST_POPPED;
              state_nxt      = S_POP;
            end
          end else if (!req.waiting) begin
            rsp_nxt.status = bspq_pkg::ST_NOT_WAITING;
            state_nxt      = S_DONE;
          end else begin
            rsp_nxt.status = bspq_pkg::ST_INSERTED;
            state_nxt      = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Read slot idx while checking the entry read in the previous cycle.
        if ((idx_r != '0) && key_gt && !found_r) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_dec;
        end
        dup_nxt = dup_any;
        if (idx_r == cnt_r) begin
          priority if (dup_any) begin
            rsp_nxt.status = bspq_pkg::ST_DUPLICATE;
            state_nxt      = S_DONE;
          end else if (cnt_r == CNT_W'(QUEUE_DEPTH)) begin
            rsp_nxt.status = bspq_pkg::ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            pos_nxt   = pos_fin;
            idx_nxt   = cnt_r;
            pend_nxt  = 1'b0;
            state_nxt = S_SHIFT;
          end
        end else begin
          idx_nxt = idx_inc;
        end
      end

      S_SHIFT: begin
        // Move entries up by one slot from the tail down to the insert point.
        ram_raddr = {bank_r, idx_dec[SLOT_W-1:0]};
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = {bank_r, idx_inc[SLOT_W-1:0]};
          ram_wdata = ram_rdata;
        end
        if (idx_r > pos_r) begin
          idx_nxt  = idx_dec;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            ram_we         = 1'b1;
            ram_waddr      = {bank_r, pos_r[SLOT_W-1:0]};
            ram_wdata      = req_r.entry;
            cnt_nxt        = cnt_r + CNT_W'(1);
            rsp_nxt.status = bspq_pkg::ST_INSERTED;
            state_nxt      = S_DONE;
          end
        end
      end

      S_POP: begin
        // Slot 0 is the head; every later slot moves down by one.
        if (idx_r < cnt_r) begin
          idx_nxt  = idx_inc;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (idx_r == CNT_W'(1)) begin
            rsp_nxt.entry = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = {bank_r, idx_dec2[SLOT_W-1:0]};
            ram_wdata = ram_rdata;
          end
        end
        if ((idx_r == cnt_r) && !pend_r) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
    req_r   <= req_nxt;
    bank_r  <= bank_nxt;
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    dup_r   <= dup_nxt;
    found_r <= found_nxt;
    rsp_r   <= rsp_nxt;
  end

  bspq_ram #(
    .WIDTH (bspq_pkg::ENTRY_W),
    .DEPTH (2 ** ADDR_W)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ready   = (state_r == S_IDLE);
  assign rsp     = rsp_r;
  assign rsp_cnt = cnt_r;

endmodule

`default_nettype wire

// ----- rtl/core/banked_sorted_priority_queue.sv -----
// Banked sorted priority queue: per-bank fill levels, result register and top level.
//
// The block keeps one sorted queue per department bank. Each input transaction
// on the in_ channel either inserts an entry (in_tuser = 0) or pops the head of
// the addressed bank (in_tuser = 1). Entries are ordered by priority, then by
// registration time; equal keys are served in arrival order. Every input
// transaction yields exactly one output transaction on the out_ channel with a
// status code, the popped entry (zero unless popped) and the bank fill level.
// All entries of all banks live in one simple dual-port memory whose single
// read port and one compare unit are stepped by a small sequencer.
// An insert scans all bank entries for a duplicate and the insert point, shifts
// the entries from the tail to that point up by one slot, writes the new entry
// and hands over the result; a pop reads the head and moves every later entry down
// by one. A duplicate or full rejection ends after the scan; other ignored operations
// go straight to the result. in_tready is high only while the sequencer is idle, so
// one item is in work at a time; the read port paces one entry per cycle. The
// result register lets a new item be accepted while the previous result still waits;
// if the receiver stalls, the next result waits in the sequencer until it is free.
// Reset clears all fill levels and the handshake state; memory contents need
// no clearing because only entries below a bank's fill level are ever used.
`default_nettype none

module banked_sorted_priority_queue #(
  parameter int DEPARTMENTS = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // Fields from bit 0: department[3], visit_id[32], priority_req[3],
  // reg_time[32], is_waiting[1], zero pad[1].
  input  wire logic [bspq_pkg::IN_TDATA_W-1:0]    in_tdata,
  // Fields from bit 0: action[1] (0 insert, 1 pop).
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // Fields from bit 0: status[3], out_visit_id[32], out_priority[3],
  // out_reg_time[32], queue_empty[1], queue_count[5], zero pad[4].
  output logic [bspq_pkg::OUT_TDATA_W-1:0]        out_tdata
);

  localparam int BANK_W = (DEPARTMENTS > 1) ? $clog2(DEPARTMENTS) : 1;
  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int DX_W   = (BANK_W > bspq_pkg::DEPT_W) ? BANK_W : bspq_pkg::DEPT_W;
  localparam int PAD_W  = bspq_pkg::OUT_TDATA_W - 76;

  // Input field unpacking.
  logic [bspq_pkg::DEPT_W-1:0] in_dept;
  logic [DX_W-1:0]             in_dept_ext;
  logic [BANK_W-1:0]           in_bank;
  logic                        in_bank_ok;
  logic                        in_fire;
  bspq_pkg::req_t              in_req;

  assign in_dept            = in_tdata[2:0];
  assign in_dept_ext        = DX_W'(in_dept);
  assign in_bank            = in_dept_ext[BANK_W-1:0];
  assign in_bank_ok         = (32'(in_dept) < 32'(DEPARTMENTS));
  assign in_req.action      = bspq_pkg::action_t'(in_tuser);
  assign in_req.entry.id    = in_tdata[34:3];
  assign in_req.entry.prio  = in_tdata[37:35];
  assign in_req.entry.rtime = in_tdata[69:38];
  assign in_req.waiting     = in_tdata[70];
  assign in_fire            = in_tvalid && in_tready;

  // Per-bank fill levels; reset clears them to zero.
  logic [CNT_W-1:0]  bank_count_r [DEPARTMENTS];
  logic [CNT_W-1:0]  in_bank_cnt;
  logic [BANK_W-1:0] bank_r;
  logic              bank_ok_r;

  assign in_bank_cnt = in_bank_ok ? bank_count_r[in_bank] : '0;

  // Result register between the sequencer and the receiver.
  logic                                 out_valid_r;
  logic [bspq_pkg::OUT_TDATA_W-1:0]     out_data_r;
  logic [bspq_pkg::OUT_TDATA_W-1:0]     out_data_nxt;

  // Sequencer hookup.
  logic              seq_ready;
  logic              seq_done;
  bspq_pkg::rsp_t    seq_rsp;
  logic [CNT_W-1:0]  seq_cnt;
  logic              out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = seq_ready;

  bspq_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .BANK_W      (BANK_W),
    .SLOT_W      (SLOT_W),
    .CNT_W       (CNT_W)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .req      (in_req),
    .bank     (in_bank),
    .bank_ok  (in_bank_ok),
    .bank_cnt (in_bank_cnt),
    .out_free (out_free),
    .ready    (seq_ready),
    .done     (seq_done),
    .rsp      (seq_rsp),
    .rsp_cnt  (seq_cnt)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      bank_r    <= in_bank;
      bank_ok_r <= in_bank_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < DEPARTMENTS; b++) begin
        bank_count_r[b] <= '0;
      end
    end else if (seq_done && bank_ok_r) begin
      bank_count_r[bank_r] <= seq_cnt;
    end
  end

  assign out_data_nxt = {
    {PAD_W{1'b0}},
    bspq_pkg::COUNT_W'(seq_cnt),
    (seq_cnt == '0),
    seq_rsp.entry.rtime,
    seq_rsp.entry.prio,
    seq_rsp.entry.id,
    seq_rsp.status
  };

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A finished result is only handed over when the result register can take it.
  assert property (@(posedge clk) disable iff (!rst_n)
    seq_done |-> (!out_valid_r || out_tready))
    else $error("result handed over while the result register is occupied");

  // One item at a time: after an accepted transaction the input side closes.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input accepted again before the item finished");

  // A bank never reports more entries than it can hold.
  assert property (@(posedge clk) disable iff (!rst_n)
    seq_done |-> (32'(seq_cnt) <= 32'(QUEUE_DEPTH)))
    else $error("bank fill level exceeds its depth");

  // A pop result always carries a fill level one below the stored level.
  assert property (@(posedge clk) disable iff (!rst_n)
    (seq_done && (seq_rsp.status == bspq_pkg::ST_POPPED)) |->
      ((seq_cnt + CNT_W'(1)) == bank_count_r[bank_r]))
    else $error("pop did not lower the fill level by one");

endmodule

`default_nettype wire
